>>> hdl/bhs_pkg.sv
// ----------------------------------------------------------------------------
// bhs_pkg
// Types, constants and Q16.16 arithmetic helpers shared by the bilinear
// hysteretic spring datapath.
// ----------------------------------------------------------------------------
package bhs_pkg;

    // Field widths
    localparam int Q_W        = 32;  // signed Q16.16 data
    localparam int K_W        = 31;  // unsigned Q15.16 register values
    localparam int QSHIFT     = 16;  // fraction bits
    localparam int CFG_IDX_W  = 2;   // register index
    localparam int PROD_W     = 64;  // exact product width
    localparam int PROD_SH_W  = 47;  // product after the fraction shift

    // Direction of the last deformation increment
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ELASTIC_STIFFNESS  = 2'd0,
        REG_YIELD_STIFFNESS    = 2'd1,
        REG_YIELD_DISPLACEMENT = 2'd2,
        REG_YIELD_FORCE        = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [K_W-1:0] elastic_stiffness;
        logic [K_W-1:0] yield_stiffness;
        logic [K_W-1:0] yield_displacement;
        logic [K_W-1:0] yield_force;
    } t_spring_cfg;

    // Committed spring state
    typedef struct packed {
        logic signed [Q_W-1:0] deformation;
        t_dir                  direction;
        logic signed [Q_W-1:0] spring_force;
        logic                  yielded;
    } t_spring_state;

    typedef struct packed {
        logic signed [Q_W-1:0] spring_force;
        logic [K_W-1:0]        tangent_stiffness;
        logic                  yielded;
        logic signed [Q_W-1:0] deformation;
    } t_result;

    // Saturate a 33-bit exact sum to 32 bits
    function automatic logic signed [Q_W-1:0] sat33(input logic signed [Q_W:0] v);
        logic signed [Q_W-1:0] r;
        if (v[Q_W] != v[Q_W-1]) begin
            r = v[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    // Saturate a shifted product to 32 bits
    function automatic logic signed [Q_W-1:0] sat_prod(
        input logic signed [PROD_SH_W-1:0] v
    );
        logic signed [Q_W-1:0] r;
        if (!v[PROD_SH_W-1] && (|v[PROD_SH_W-2:Q_W-1])) begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end else if (v[PROD_SH_W-1] && !(&v[PROD_SH_W-2:Q_W-1])) begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    // Q16.16 product, floor of the shifted exact product, saturated
    function automatic logic signed [Q_W-1:0] qmul(
        input logic signed [Q_W-1:0] a,
        input logic [K_W-1:0]        k
    );
        logic signed [PROD_W-1:0] p;
        p = $signed({{(PROD_W-Q_W){a[Q_W-1]}}, a}) *
            $signed({{(PROD_W-K_W){1'b0}}, k});
        return sat_prod(p[PROD_SH_W+QSHIFT-1:QSHIFT]);
    endfunction

    // Sign-extend a Q16.16 value by one bit
    function automatic logic signed [Q_W:0] ext(input logic signed [Q_W-1:0] v);
        return {v[Q_W-1], v};
    endfunction

    // Zero-extend a register value to 33 bits
    function automatic logic signed [Q_W:0] kext(input logic [K_W-1:0] v);
        return {{(Q_W+1-K_W){1'b0}}, v};
    endfunction

endpackage

>>> hdl/bhs_in_if.sv
// ----------------------------------------------------------------------------
// bhs_in_if
// Request channel carrying the end displacements and the commit flag.
// ----------------------------------------------------------------------------
interface bhs_in_if;
    logic                           valid;
    logic                           ready;
    logic signed [bhs_pkg::Q_W-1:0] disp_i;
    logic signed [bhs_pkg::Q_W-1:0] disp_j;
    logic                           commit;

    modport source (output valid, disp_i, disp_j, commit, input ready);
    modport sink   (input valid, disp_i, disp_j, commit, output ready);
endinterface

>>> hdl/bhs_out_if.sv
// ----------------------------------------------------------------------------
// bhs_out_if
// Result channel carrying force, tangent stiffness, state flag, deformation.
// ----------------------------------------------------------------------------
interface bhs_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [bhs_pkg::Q_W-1:0] spring_force;
    logic [bhs_pkg::K_W-1:0]        tangent_stiffness;
    logic                           yielded;
    logic signed [bhs_pkg::Q_W-1:0] deformation;

    modport source (output valid, spring_force, tangent_stiffness, yielded, deformation,
                    input ready);
    modport sink   (input valid, spring_force, tangent_stiffness, yielded, deformation,
                    output ready);
endinterface

>>> hdl/bhs_eval.sv
// ----------------------------------------------------------------------------
// bhs_eval
// Spring state evaluation: trial force, bounding lines, elastic/yield
// switching and the next committed state for one request.
// ----------------------------------------------------------------------------
module bhs_eval (
    input  logic signed [bhs_pkg::Q_W-1:0] i_u,       // deformation
    input  logic signed [bhs_pkg::Q_W-1:0] i_u_minus, // u - uy, saturated
    input  logic signed [bhs_pkg::Q_W-1:0] i_u_plus,  // u + uy, saturated
    input  bhs_pkg::t_spring_state         i_state,
    input  bhs_pkg::t_spring_cfg           i_cfg,
    output bhs_pkg::t_result               o_result,
    output bhs_pkg::t_spring_state         o_next_state
);
    import bhs_pkg::*;

    logic signed [Q_W-1:0] w_du;
    logic signed [Q_W-1:0] w_p0;
    logic signed [Q_W-1:0] w_p1;
    logic signed [Q_W-1:0] w_ftry;
    logic signed [Q_W-1:0] w_frev;
    logic signed [Q_W-1:0] w_bup;
    logic signed [Q_W-1:0] w_bdn;
    logic [K_W-1:0]        w_kp;
    t_dir                  w_dnow;
    logic signed [Q_W-1:0] w_force;
    logic [K_W-1:0]        w_k;
    logic                  w_st;

    // Increment and its products with both stiffnesses
    assign w_du   = sat33(ext(i_u) - ext(i_state.deformation));
    assign w_p0   = qmul(w_du, i_cfg.elastic_stiffness);
    assign w_p1   = qmul(w_du, i_cfg.yield_stiffness);
    assign w_kp   = i_state.yielded ? i_cfg.yield_stiffness : i_cfg.elastic_stiffness;
    assign w_ftry = sat33(ext(i_state.spring_force) + ext(i_state.yielded ? w_p1 : w_p0));
    assign w_frev = sat33(ext(i_state.spring_force) + ext(w_p0));

    // Post-yield bounding lines
    assign w_bup = sat33(kext(i_cfg.yield_force) + ext(qmul(i_u_minus, i_cfg.yield_stiffness)));
    assign w_bdn = sat33(ext(qmul(i_u_plus, i_cfg.yield_stiffness)) - kext(i_cfg.yield_force));

    // Direction of this increment
    always_comb begin
        if (w_du == '0) begin
            w_dnow = DIR_NONE;
        end else if (w_du[Q_W-1]) begin
            w_dnow = DIR_DOWN;
        end else begin
            w_dnow = DIR_UP;
        end
    end

    // Select force, tangent and state flag
    always_comb begin
        w_force = w_ftry;
        w_k     = i_cfg.elastic_stiffness;
        w_st    = i_state.yielded;
        if (w_dnow == DIR_NONE) begin
            // no movement: hold the committed response
            w_force = i_state.spring_force;
            w_k     = w_kp;
        end else if (!i_state.yielded) begin
            // elastic: clip to the bounding line in the loading direction
            if (w_dnow == DIR_UP && w_ftry > w_bup) begin
                w_force = w_bup;
                w_k     = i_cfg.yield_stiffness;
                w_st    = 1'b1;
            end else if (w_dnow == DIR_DOWN && w_ftry < w_bdn) begin
                w_force = w_bdn;
                w_k     = i_cfg.yield_stiffness;
                w_st    = 1'b1;
            end
        end else if (i_state.direction != DIR_NONE && i_state.direction == w_dnow) begin
            // yielded, still loading the same way
            w_k = i_cfg.yield_stiffness;
        end else begin
            // reversal or no committed direction: unload elastically, clip to either line
            w_force = w_frev;
            w_st    = 1'b0;
            if (w_frev > w_bup) begin
                w_force = w_bup;
                w_k     = i_cfg.yield_stiffness;
                w_st    = 1'b1;
            end else if (w_frev < w_bdn) begin
                w_force = w_bdn;
                w_k     = i_cfg.yield_stiffness;
                w_st    = 1'b1;
            end
        end
    end

    assign o_result.spring_force      = w_force;
    assign o_result.tangent_stiffness = w_k;
    assign o_result.yielded           = w_st;
    assign o_result.deformation       = i_u;

    assign o_next_state.deformation  = i_u;
    assign o_next_state.direction    = w_dnow;
    assign o_next_state.spring_force = w_force;
    assign o_next_state.yielded      = w_st;

endmodule

>>> hdl/bilinear_hysteretic_spring.sv
// ----------------------------------------------------------------------------
// bilinear_hysteretic_spring
// Bilinear hysteretic spring with kinematic hardening in Q16.16: returns
// force, tangent stiffness, yield flag and deformation for each request.
// ----------------------------------------------------------------------------
//
//  Port        Dir   Handshake      Carries
//  i_spring    in    valid/ready    disp_i, disp_j, commit
//  o_spring    out   valid/ready    spring_force, tangent_stiffness, yielded,
//                                   deformation
//  i_cfg_*     in    write enable   register index, 31-bit register data
//
//  One request per cycle sustained while o_spring is ready; a result passes
//  through the input register and then the result register.
//  The clock is set by the single evaluation pass: deformation subtract, offset
//  by uy, one 32x31 multiply, saturating add, bound compare and select, with the
//  committed state fed back to the next request. Synchronous reset clears
//  configuration, committed state and all valids. A stalled result holds in the
//  output register; the input register takes one more request, then drops ready.
//
module bilinear_hysteretic_spring (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bhs_in_if.sink                              i_spring,
    bhs_out_if.source                           o_spring,
    input  logic                                i_cfg_we,
    input  logic [bhs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bhs_pkg::K_W-1:0]             i_cfg_data
);
    import bhs_pkg::*;

    t_spring_cfg           r_cfg;
    t_spring_state         r_state;
    t_spring_state         n_state;

    logic                  r_s1_valid;
    logic signed [Q_W-1:0] r_s1_disp_i;
    logic signed [Q_W-1:0] r_s1_disp_j;
    logic                  r_s1_commit;

    logic                  r_out_valid;
    t_result               r_out;
    t_result               n_out;

    logic signed [Q_W-1:0] w_u;
    logic signed [Q_W-1:0] w_u_minus;
    logic signed [Q_W-1:0] w_u_plus;
    logic                  w_out_adv;
    logic                  w_s1_adv;
    logic                  w_s1_free;
    logic                  w_in_take;

    // Stage flow control
    assign w_out_adv = !r_out_valid || o_spring.ready;
    assign w_s1_adv  = r_s1_valid && w_out_adv;
    assign w_s1_free = !r_s1_valid || w_out_adv;
    assign w_in_take = i_spring.valid && w_s1_free;

    assign i_spring.ready = w_s1_free;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ELASTIC_STIFFNESS:  r_cfg.elastic_stiffness  <= i_cfg_data;
                REG_YIELD_STIFFNESS:    r_cfg.yield_stiffness    <= i_cfg_data;
                REG_YIELD_DISPLACEMENT: r_cfg.yield_displacement <= i_cfg_data;
                REG_YIELD_FORCE:        r_cfg.yield_force        <= i_cfg_data;
                default:                r_cfg                    <= r_cfg;
            endcase
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_spring.valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_disp_i <= i_spring.disp_i;
            r_s1_disp_j <= i_spring.disp_j;
            r_s1_commit <= i_spring.commit;
        end
    end

    // Form the deformation and its offsets by the yield displacement
    assign w_u       = sat33(ext(r_s1_disp_j) - ext(r_s1_disp_i));
    assign w_u_minus = sat33(ext(w_u) - kext(r_cfg.yield_displacement));
    assign w_u_plus  = sat33(ext(w_u) + kext(r_cfg.yield_displacement));

    // Evaluate against the committed state
    bhs_eval u_eval (
        .i_u          (w_u),
        .i_u_minus    (w_u_minus),
        .i_u_plus     (w_u_plus),
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .o_result     (n_out),
        .o_next_state (n_state)
    );

    // Commit state as the request leaves the evaluation stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{deformation: '0, direction: DIR_NONE, spring_force: '0,
                         yielded: 1'b0};
        end else if (w_s1_adv && r_s1_commit) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_spring.valid             = r_out_valid;
    assign o_spring.spring_force      = r_out.spring_force;
    assign o_spring.tangent_stiffness = r_out.tangent_stiffness;
    assign o_spring.yielded           = r_out.yielded;
    assign o_spring.deformation       = r_out.deformation;

    // Committed state only moves when a request leaves evaluation
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(w_s1_adv && r_s1_commit)) |-> $stable(r_state))
        else $error("committed state changed without a committing request");

    // A committed result matches the state it leaves behind
    a_state_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(w_s1_adv && r_s1_commit)) |->
        (r_state.spring_force == r_out.spring_force &&
         r_state.yielded == r_out.yielded &&
         r_state.deformation == r_out.deformation))
        else $error("committed state differs from delivered result");

    // A result appears only when the evaluation stage held a request
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result valid without a request in evaluation");

endmodule

>>> sim/bilinear_hysteretic_spring_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_hysteretic_spring_test
// Drives displacement requests into the spring under several register
// settings, predicts force, tangent, yield flag and deformation for each
// request from a cycle-free copy of the spring state, and compares every
// result in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module bilinear_hysteretic_spring_test;
    import bhs_pkg::*;

    localparam int             IDLE_LIMIT    = 2000;
    localparam int             MAX_PRINTED   = 40;
    localparam int             RANDOM_PHASES = 6;
    localparam int             PHASE_ITEMS   = 125;
    localparam int             QTR           = 16384;          // a quarter, Q16.16
    localparam int             Q_TOP         = 32'sh7fffffff;
    localparam int             Q_BOTTOM      = 32'sh80000000;
    localparam longint         L_TOP         = 64'sd2147483647;
    localparam longint         L_BOTTOM      = -64'sd2147483648;
    localparam logic [K_W-1:0] K_MAX         = {K_W{1'b1}};

    typedef enum logic [1:0] {
        RX_FLOW,
        RX_COIN,
        RX_SPARSE,
        RX_BLOCKS
    } t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [K_W-1:0]       i_cfg_data;

    bhs_in_if  spring_req ();
    bhs_out_if spring_rsp ();

    bilinear_hysteretic_spring u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_spring   (spring_req),
        .o_spring   (spring_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Register copies and committed spring state
    logic [K_W-1:0] k_elastic = '0;
    logic [K_W-1:0] k_yield   = '0;
    logic [K_W-1:0] u_yield   = '0;
    logic [K_W-1:0] f_yield   = '0;
    int             committed_def     = 0;
    t_dir           committed_dir     = DIR_NONE;
    int             committed_force   = 0;
    bit             committed_yielded = 1'b0;

    t_result predicted_responses[$];
    int      error_count  = 0;
    int      result_count = 0;
    int      idle_cycles  = 0;
    int      burst_left   = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int clamp32(longint v);
        if (v > L_TOP) return Q_TOP;
        if (v < L_BOTTOM) return Q_BOTTOM;
        return int'(v);
    endfunction

    // Q16.16 product, floored, saturated
    function automatic int fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> 16);
    endfunction

    // Evaluate one request against the committed state; commit if asked
    function automatic t_result spring_response(int di, int dj, bit cm);
        longint  k0, k1, uy, fy, kp, k;
        int      u, du, ftry, bup, bdn, f;
        bit      yld;
        t_dir    dnow;
        t_result r;
        k0   = longint'(k_elastic);
        k1   = longint'(k_yield);
        uy   = longint'(u_yield);
        fy   = longint'(f_yield);
        u    = clamp32(longint'(dj) - longint'(di));
        du   = clamp32(longint'(u) - longint'(committed_def));
        kp   = committed_yielded ? k1 : k0;
        ftry = clamp32(longint'(committed_force) + fx_mul(du, kp));
        bup  = clamp32(fy + fx_mul(k1, clamp32(longint'(u) - uy)));
        bdn  = clamp32(-fy + fx_mul(k1, clamp32(longint'(u) + uy)));
        dnow = (du > 0) ? DIR_UP : ((du < 0) ? DIR_DOWN : DIR_NONE);
        yld  = committed_yielded;

        if (du == 0) begin
            // hold the committed force and tangent
            k = kp;
            f = committed_force;
        end else if (!committed_yielded) begin
            k = k0;
            f = ftry;
            if (du > 0 && ftry > bup) begin
                f = bup; k = k1; yld = 1'b1;
            end else if (du < 0 && ftry < bdn) begin
                f = bdn; k = k1; yld = 1'b1;
            end
        end else if (committed_dir != DIR_NONE && committed_dir == dnow) begin
            // keep sliding along the bounding line
            f = ftry;
            k = k1;
        end else begin
            // unload elastically, then clip to either line
            k   = k0;
            f   = clamp32(longint'(committed_force) + fx_mul(k0, du));
            yld = 1'b0;
            if (f > bup) begin
                f = bup; k = k1; yld = 1'b1;
            end else if (f < bdn) begin
                f = bdn; k = k1; yld = 1'b1;
            end
        end

        r.spring_force      = f;
        r.tangent_stiffness = k[K_W-1:0];
        r.yielded           = yld;
        r.deformation       = u;
        if (cm) begin
            committed_def     = u;
            committed_dir     = dnow;
            committed_force   = f;
            committed_yielded = yld;
        end
        return r;
    endfunction

    task automatic report_error(string what, longint got, longint want);
        if (error_count < MAX_PRINTED)
            $display("ERROR @%0t result %0d: %s got %0h, expected %0h",
                     $realtime, result_count, what, got, want);
        error_count++;
    endtask

    // Send one request, opening a random gap between bursts
    task automatic send_item(int di, int dj, bit cm);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                spring_req.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 20);
        end
        @(negedge i_clk);
        spring_req.valid  <= 1'b1;
        spring_req.disp_i <= di;
        spring_req.disp_j <= dj;
        spring_req.commit <= cm;
        do @(posedge i_clk); while (!spring_req.ready);
        predicted_responses.push_back(spring_response(di, dj, cm));
        burst_left--;
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic pause_until_drained();
        @(negedge i_clk);
        spring_req.valid <= 1'b0;
        burst_left = 0;
        while (predicted_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all four registers while the block is idle
    task automatic set_config(logic [K_W-1:0] k0, logic [K_W-1:0] k1,
                              logic [K_W-1:0] uy, logic [K_W-1:0] fy);
        t_reg_idx       ri;
        logic [K_W-1:0] val;
        pause_until_drained();
        ri = REG_ELASTIC_STIFFNESS;
        repeat (4) begin
            case (ri)
                REG_ELASTIC_STIFFNESS:  begin val = k0; k_elastic = k0; end
                REG_YIELD_STIFFNESS:    begin val = k1; k_yield   = k1; end
                REG_YIELD_DISPLACEMENT: begin val = uy; u_yield   = uy; end
                default:                begin val = fy; f_yield   = fy; end
            endcase
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= ri;
            i_cfg_data <= val;
            @(posedge i_clk);
            ri = ri.next();
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // All registers still zero after reset
    task automatic test_reset_defaults();
        send_item(0, 4 * QTR, 1'b1);
        send_item(-5, 12345, 1'b1);
        send_item(Q_TOP, 0, 1'b0);
    endtask

    // One hysteresis loop with every state transition
    task automatic test_loading_cycle();
        set_config(100 << 16, 5 << 16, 1 << 16, 100 << 16);
        send_item(0, 2 * QTR, 1'b1);        // elastic load
        send_item(QTR, 3 * QTR, 1'b1);      // no movement
        send_item(0, 8 * QTR, 1'b1);        // yield on upper line
        send_item(0, 12 * QTR, 1'b1);       // yielded, same direction
        send_item(0, 10 * QTR, 1'b1);       // reversal back to elastic
        send_item(0, -4 * QTR, 1'b1);       // yield on lower line
        send_item(0, -8 * QTR, 1'b0);       // trial, not committed
        send_item(0, -8 * QTR, 1'b1);       // yielded, same direction
        send_item(0, -4 * QTR, 1'b1);       // reversal back to elastic
        send_item(0, 24 * QTR, 1'b1);       // yield up again
        send_item(0, -80 * QTR, 1'b1);      // reversal clipped to lower line
        send_item(0, -80 * QTR, 1'b1);      // yielded with no movement
        send_item(0, -84 * QTR, 1'b1);      // yielded, no committed direction
        send_item(0, -84 * QTR, 1'b0);
    endtask

    // Full-scale registers and displacements
    task automatic test_saturation_extremes();
        set_config(K_MAX, K_MAX, K_MAX, K_MAX);
        send_item(Q_BOTTOM, Q_TOP, 1'b1);
        send_item(Q_TOP, Q_BOTTOM, 1'b1);
        send_item(Q_TOP, Q_TOP, 1'b0);
        send_item(0, 0, 1'b1);
        set_config(K_MAX, '0, '0, '0);
        send_item(0, Q_TOP, 1'b1);
        send_item(0, -1, 1'b1);
        send_item(-1, 0, 1'b0);
    endtask

    // Random walks around the yield band, with noise, under several settings
    task automatic test_random_loading();
        longint k0, k1, uy, fy, sc, pos, off;
        int     di, dj, pick;
        bit     cm;
        di = 0;
        dj = 0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            k0 = $urandom_range(1 << 14, 1 << 24);
            k1 = (k0 * longint'($urandom_range(0, 65536))) >>> 16;
            uy = $urandom_range(1 << 10, 1 << 18);
            fy = (k0 * uy) >>> 16;
            if (fy > longint'(K_MAX)) fy = longint'(K_MAX);
            sc = uy;
            case (ph)
                1: k1 = 0;
                2: begin
                    k0 = K_MAX; k1 = K_MAX; uy = K_MAX; fy = K_MAX;
                    sc = 1 << 28;
                end
                3: begin
                    k0 = $urandom & K_MAX; k1 = $urandom & K_MAX;
                    uy = $urandom & K_MAX; fy = $urandom & K_MAX;
                    sc = longint'(1) << $urandom_range(8, 29);
                end
                5: k1 = k0;
                default: ;
            endcase
            set_config(k0[K_W-1:0], k1[K_W-1:0], uy[K_W-1:0], fy[K_W-1:0]);
            pos = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    di = $urandom;
                    dj = $urandom;
                end else if (pick >= 14) begin
                    pos = pos + longint'($urandom_range(0, int'(4 * sc))) - 2 * sc;
                    if (pos > 12 * sc || pos < -12 * sc) pos = pos / 2;
                    off = longint'($urandom_range(0, int'(2 * sc))) - sc;
                    di  = clamp32(off);
                    dj  = clamp32(pos + off);
                end
                cm = ($urandom_range(0, 99) < 85);
                send_item(di, dj, cm);
                if (ph == 1 && n == 60) pause_until_drained();
            end
        end
    endtask

    // Stall the result channel in changing patterns
    initial begin : sink_stalls
        t_rx_mode mode;
        int       mode_left;
        int       block_left;
        int       cyc;
        spring_rsp.ready = 1'b0;
        mode       = RX_FLOW;
        mode_left  = 0;
        block_left = 0;
        cyc        = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                RX_FLOW:   spring_rsp.ready <= 1'b1;
                RX_COIN:   spring_rsp.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: spring_rsp.ready <= (cyc % 4 == 0);
                default: begin
                    if (block_left > 0) begin
                        spring_rsp.ready <= 1'b0;
                        block_left--;
                    end else begin
                        spring_rsp.ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0) block_left = $urandom_range(1, 16);
                    end
                end
            endcase
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && spring_rsp.valid && spring_rsp.ready) begin
            if (predicted_responses.size() == 0) begin
                report_error("unexpected result, force", spring_rsp.spring_force, 0);
            end else begin
                want = predicted_responses.pop_front();
                if (spring_rsp.spring_force !== want.spring_force)
                    report_error("spring_force", spring_rsp.spring_force, want.spring_force);
                if (spring_rsp.tangent_stiffness !== want.tangent_stiffness)
                    report_error("tangent_stiffness", spring_rsp.tangent_stiffness,
                                 want.tangent_stiffness);
                if (spring_rsp.yielded !== want.yielded)
                    report_error("yielded", spring_rsp.yielded, want.yielded);
                if (spring_rsp.deformation !== want.deformation)
                    report_error("deformation", spring_rsp.deformation, want.deformation);
            end
            result_count++;
        end
    end

    // End the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((spring_req.valid && spring_req.ready) || (spring_rsp.valid && spring_rsp.ready)
                || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("bilinear_hysteretic_spring: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = REG_ELASTIC_STIFFNESS;
        i_cfg_data        = '0;
        spring_req.valid  = 1'b0;
        spring_req.disp_i = '0;
        spring_req.disp_j = '0;
        spring_req.commit = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_loading_cycle();
        test_saturation_extremes();
        test_random_loading();

        pause_until_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("bilinear_hysteretic_spring: match");
        end else begin
            $display("bilinear_hysteretic_spring: mismatch");
        end
        $finish;
    end

endmodule
